[rtl/wake_word_posterior_listen_fsm_macros.svh]
// Assertion macros for the wake word listen block.
`ifndef WAKE_WORD_POSTERIOR_LISTEN_FSM_MACROS_SVH
`define WAKE_WORD_POSTERIOR_LISTEN_FSM_MACROS_SVH
`ifndef SYNTHESIS
`define WWPL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WWPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WWPL_ASSERT(label, clk, rst_n, prop, msg)
`define WWPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/wwpl_pkg.sv]
// Shared types and constants of the wake word listen block.
`timescale 1ns / 1ps
package wwpl_pkg;
	localparam int WINDOW_MAX  = 16;
	localparam int TIME_WIDTH  = 48;
	localparam int NUM_SLOTS   = 3;
	localparam int IDX_W       = $clog2(WINDOW_MAX);
	localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W       = $clog2(WINDOW_MAX * 255 + 1);
	localparam int THR_W       = 8 + LEN_W;
	localparam int HOLD_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int SLOT_WAKE = 0;
	localparam int SLOT_ON   = 1;
	localparam int SLOT_OFF  = 2;

	localparam logic [7:0]  DEF_WAKE_CUTOFF = 8'd200;
	localparam logic [7:0]  DEF_CMD_CUTOFF  = 8'd200;
	localparam logic [4:0]  DEF_WAKE_LEN    = 5'd5;
	localparam logic [4:0]  DEF_CMD_LEN     = 5'd3;
	localparam logic [14:0] DEF_WARMUP      = 15'd20;
	localparam logic [14:0] DEF_COOLDOWN    = 15'd50;
	localparam logic [31:0] DEF_LISTEN_TIME = 32'd5000000;
	localparam logic [31:0] DEF_GAP_TIME    = 32'd500000;

	typedef enum logic {
		OP_BLOCK = 1'b0,
		OP_SLICE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_WAKE    = 3'd1,
		EV_ON      = 3'd2,
		EV_OFF     = 3'd3,
		EV_TIMEOUT = 3'd4,
		EV_GAP     = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAKE_CUTOFF = 3'd0,
		REG_CMD_CUTOFF  = 3'd1,
		REG_WAKE_LEN    = 3'd2,
		REG_CMD_LEN     = 3'd3,
		REG_WARMUP      = 3'd4,
		REG_COOLDOWN    = 3'd5,
		REG_LISTEN_TIME = 3'd6,
		REG_GAP_TIME    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		op_t                             op;
		logic [TIME_WIDTH-1:0]           now;
		logic [NUM_SLOTS-1:0]            done;
		logic [NUM_SLOTS-1:0][7:0]       prob;
	} work_t;

	typedef struct packed {
		logic  push;
		work_t data;
	} q_wr_t;

	typedef struct packed {
		logic  valid;
		work_t data;
	} q_rd_t;

	typedef struct packed {
		logic [WINDOW_MAX-1:0][7:0] win;
		logic [SUM_W-1:0]           sum;
		logic [IDX_W-1:0]           idx;
		logic [HOLD_W-1:0]          hold;
		logic [7:0]                 last;
	} slot_t;

	typedef struct packed {
		slot_t s;
		logic  hit;
	} feed_t;
endpackage

[rtl/wwpl_item_if.sv]
// Input channel: block starts and feature slices.
`timescale 1ns / 1ps
interface wwpl_item_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [wwpl_pkg::TIME_WIDTH-1:0] now_us;
	logic                           wake_done;
	logic [7:0]                     wake_prob;
	logic                           on_done;
	logic [7:0]                     on_prob;
	logic                           off_done;
	logic [7:0]                     off_prob;

	modport source(output valid, cmd, now_us, wake_done, wake_prob, on_done, on_prob,
		off_done, off_prob, input ready);
	modport sink(input valid, cmd, now_us, wake_done, wake_prob, on_done, on_prob,
		off_done, off_prob, output ready);
endinterface

[rtl/wwpl_res_if.sv]
// Output channel: detection events.
`timescale 1ns / 1ps
interface wwpl_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       listening;
	logic [7:0] hit_prob;

	modport source(output valid, event_res, listening, hit_prob, input ready);
	modport sink(input valid, event_res, listening, hit_prob, output ready);
endinterface

[rtl/wwpl_front.sv]
// Front end: takes input words and classifies them into queue entries.
`timescale 1ns / 1ps
module wwpl_front (
	wwpl_item_if.sink       item,
	input  logic            full,
	output wwpl_pkg::q_wr_t wr
);
	assign item.ready = !full;

	always_comb begin
		wr.push                          = item.valid && !full;
		wr.data.op                       = wwpl_pkg::op_t'(item.cmd);
		wr.data.now                      = '0;
		wr.data.done                     = '0;
		wr.data.prob                     = '0;
		unique case (wr.data.op)
			wwpl_pkg::OP_BLOCK: begin
				wr.data.now = item.now_us;
			end
			wwpl_pkg::OP_SLICE: begin
				wr.data.done[wwpl_pkg::SLOT_WAKE] = item.wake_done;
				wr.data.done[wwpl_pkg::SLOT_ON]   = item.on_done;
				wr.data.done[wwpl_pkg::SLOT_OFF]  = item.off_done;
				wr.data.prob[wwpl_pkg::SLOT_WAKE] = item.wake_prob;
				wr.data.prob[wwpl_pkg::SLOT_ON]   = item.on_prob;
				wr.data.prob[wwpl_pkg::SLOT_OFF]  = item.off_prob;
			end
			default: ;
		endcase
	end
endmodule

[rtl/wwpl_queue.sv]
// Short FIFO between front and back end.
`timescale 1ns / 1ps
`include "wake_word_posterior_listen_fsm_macros.svh"
module wwpl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  wwpl_pkg::q_wr_t wr,
	output logic            full,
	output wwpl_pkg::q_rd_t rd,
	input  logic            pop
);
	wwpl_pkg::work_t                   mem_q [wwpl_pkg::QUEUE_DEPTH];
	logic [wwpl_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [wwpl_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [wwpl_pkg::QCNT_W-1:0]       count_q;

	function automatic logic [wwpl_pkg::QPTR_W-1:0] next_ptr(
		input logic [wwpl_pkg::QPTR_W-1:0] p);
		return (p == wwpl_pkg::QPTR_W'(wwpl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == wwpl_pkg::QCNT_W'(wwpl_pkg::QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !wr.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`WWPL_ASSERT(a_count_bound, clk, arst_n, count_q <= wwpl_pkg::QCNT_W'(wwpl_pkg::QUEUE_DEPTH), "queue count over depth")
	`WWPL_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !wr.push, count_q == $past(count_q) - 1'b1, "pop did not drain")
endmodule

[rtl/wwpl_back.sv]
// Back end: slot windows, listen control, config registers and result register.
`timescale 1ns / 1ps
`include "wake_word_posterior_listen_fsm_macros.svh"
module wwpl_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wwpl_pkg::q_rd_t                    rd,
	output logic                               pop,
	input  logic                               cfg_we,
	input  logic [wwpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wwpl_pkg::CFG_DATA_W-1:0]    cfg_data,
	wwpl_res_if.source                         res
);
	localparam int TW = wwpl_pkg::TIME_WIDTH;

	logic [7:0]            wake_cut_q;
	logic [7:0]            cmd_cut_q;
	logic [4:0]            wake_len_q;
	logic [4:0]            cmd_len_q;
	logic [14:0]           warmup_q;
	logic [14:0]           cooldown_q;
	logic [31:0]           listen_time_q;
	logic [31:0]           gap_time_q;

	wwpl_pkg::slot_t       slot_q [wwpl_pkg::NUM_SLOTS];
	wwpl_pkg::slot_t       slot_d [wwpl_pkg::NUM_SLOTS];
	logic                  listen_q;
	logic                  listen_d;
	logic [TW-1:0]         deadline_q;
	logic [TW-1:0]         deadline_d;
	logic [TW-1:0]         btime_q;
	logic [TW-1:0]         btime_d;

	logic                  res_valid_q;
	wwpl_pkg::event_t      ev_q;
	logic                  listening_q;
	logic [7:0]            hp_q;
	wwpl_pkg::event_t      ev_d;
	logic [7:0]            hp_d;

	wwpl_pkg::feed_t       f_wake;
	wwpl_pkg::feed_t       f_on;
	wwpl_pkg::feed_t       f_off;
	logic [wwpl_pkg::LEN_W-1:0] wake_len;
	logic [wwpl_pkg::LEN_W-1:0] cmd_len;
	logic [TW:0]           gap_diff;
	logic [TW:0]           dl_sum;
	logic                  end_listen;

	function automatic logic [wwpl_pkg::LEN_W-1:0] eff_len(input logic [4:0] n);
		logic [wwpl_pkg::LEN_W-1:0] r;
		if (n == '0) begin
			r = wwpl_pkg::LEN_W'(1);
		end else if (int'(n) > wwpl_pkg::WINDOW_MAX) begin
			r = wwpl_pkg::LEN_W'(wwpl_pkg::WINDOW_MAX);
		end else begin
			r = wwpl_pkg::LEN_W'(n);
		end
		return r;
	endfunction

	function automatic wwpl_pkg::slot_t cleared(input logic [14:0] load);
		wwpl_pkg::slot_t s;
		s      = '0;
		s.hold = '0 - wwpl_pkg::HOLD_W'(load);
		return s;
	endfunction

	function automatic wwpl_pkg::feed_t feed(
		input wwpl_pkg::slot_t              s,
		input logic                         done,
		input logic [7:0]                   prob,
		input logic [7:0]                   cut,
		input logic [wwpl_pkg::LEN_W-1:0]   n,
		input logic [14:0]                  cool);
		wwpl_pkg::feed_t              r;
		logic [wwpl_pkg::LEN_W-1:0]   nxt;
		logic [wwpl_pkg::IDX_W-1:0]   wi;
		logic [wwpl_pkg::THR_W-1:0]   thr;
		r.s   = s;
		r.hit = 1'b0;
		thr   = wwpl_pkg::THR_W'(cut) * wwpl_pkg::THR_W'(n);
		if (done) begin
			nxt         = wwpl_pkg::LEN_W'(s.idx) + 1'b1;
			wi          = (nxt >= n) ? '0 : nxt[wwpl_pkg::IDX_W-1:0];
			r.s.idx     = wi;
			r.s.sum     = s.sum - wwpl_pkg::SUM_W'(s.win[wi]) + wwpl_pkg::SUM_W'(prob);
			r.s.win[wi] = prob;
			r.s.last    = prob;
			if (!s.hold[wwpl_pkg::HOLD_W-1] && wwpl_pkg::THR_W'(r.s.sum) >= thr) begin
				r.hit    = 1'b1;
				r.s.win  = '0;
				r.s.sum  = '0;
				r.s.hold = '0 - wwpl_pkg::HOLD_W'(cool);
			end
		end
		if (r.s.last < cut && r.s.hold[wwpl_pkg::HOLD_W-1]) begin
			r.s.hold = r.s.hold + wwpl_pkg::HOLD_W'(1);
		end
		return r;
	endfunction

	assign wake_len = eff_len(wake_len_q);
	assign cmd_len  = eff_len(cmd_len_q);
	assign pop      = rd.valid && (!res_valid_q || res.ready);
	assign gap_diff = {1'b0, rd.data.now} - {1'b0, btime_q};
	assign dl_sum   = {1'b0, btime_q} + (TW + 1)'(listen_time_q);

	always_comb begin
		f_wake = feed(slot_q[wwpl_pkg::SLOT_WAKE], rd.data.done[wwpl_pkg::SLOT_WAKE],
			rd.data.prob[wwpl_pkg::SLOT_WAKE], wake_cut_q, wake_len, cooldown_q);
		f_on   = feed(slot_q[wwpl_pkg::SLOT_ON], rd.data.done[wwpl_pkg::SLOT_ON],
			rd.data.prob[wwpl_pkg::SLOT_ON], cmd_cut_q, cmd_len, cooldown_q);
		f_off  = feed(slot_q[wwpl_pkg::SLOT_OFF], rd.data.done[wwpl_pkg::SLOT_OFF],
			rd.data.prob[wwpl_pkg::SLOT_OFF], cmd_cut_q, cmd_len, cooldown_q);
		slot_d     = slot_q;
		listen_d   = listen_q;
		deadline_d = deadline_q;
		btime_d    = btime_q;
		ev_d       = wwpl_pkg::EV_NONE;
		hp_d       = '0;
		end_listen = 1'b0;
		unique case (rd.data.op)
			wwpl_pkg::OP_BLOCK: begin
				if (listen_q) begin
					if (rd.data.now >= deadline_q) begin
						end_listen = 1'b1;
						ev_d       = wwpl_pkg::EV_TIMEOUT;
					end
				end else if (btime_q != '0 && !gap_diff[TW] &&
					gap_diff > {1'b0, TW'(gap_time_q)}) begin
					slot_d[wwpl_pkg::SLOT_WAKE] = cleared(warmup_q);
					ev_d = wwpl_pkg::EV_GAP;
				end
				btime_d = rd.data.now;
			end
			wwpl_pkg::OP_SLICE: begin
				if (listen_q) begin
					slot_d[wwpl_pkg::SLOT_ON] = f_on.s;
					if (f_on.hit) begin
						ev_d       = wwpl_pkg::EV_ON;
						hp_d       = f_on.s.last;
						end_listen = 1'b1;
					end else begin
						slot_d[wwpl_pkg::SLOT_OFF] = f_off.s;
						if (f_off.hit) begin
							ev_d       = wwpl_pkg::EV_OFF;
							hp_d       = f_off.s.last;
							end_listen = 1'b1;
						end
					end
				end else begin
					slot_d[wwpl_pkg::SLOT_WAKE] = f_wake.s;
					if (f_wake.hit) begin
						ev_d       = wwpl_pkg::EV_WAKE;
						hp_d       = f_wake.s.last;
						listen_d   = 1'b1;
						deadline_d = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
						slot_d[wwpl_pkg::SLOT_ON]  = cleared(warmup_q);
						slot_d[wwpl_pkg::SLOT_OFF] = cleared(warmup_q);
					end
				end
			end
			default: ;
		endcase
		if (end_listen) begin
			listen_d   = 1'b0;
			deadline_d = '0;
			slot_d[wwpl_pkg::SLOT_WAKE] = cleared(cooldown_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_cut_q    <= wwpl_pkg::DEF_WAKE_CUTOFF;
			cmd_cut_q     <= wwpl_pkg::DEF_CMD_CUTOFF;
			wake_len_q    <= wwpl_pkg::DEF_WAKE_LEN;
			cmd_len_q     <= wwpl_pkg::DEF_CMD_LEN;
			warmup_q      <= wwpl_pkg::DEF_WARMUP;
			cooldown_q    <= wwpl_pkg::DEF_COOLDOWN;
			listen_time_q <= wwpl_pkg::DEF_LISTEN_TIME;
			gap_time_q    <= wwpl_pkg::DEF_GAP_TIME;
		end else if (cfg_we) begin
			unique case (wwpl_pkg::cfg_reg_t'(cfg_index))
				wwpl_pkg::REG_WAKE_CUTOFF: wake_cut_q    <= cfg_data[7:0];
				wwpl_pkg::REG_CMD_CUTOFF:  cmd_cut_q     <= cfg_data[7:0];
				wwpl_pkg::REG_WAKE_LEN:    wake_len_q    <= cfg_data[4:0];
				wwpl_pkg::REG_CMD_LEN:     cmd_len_q     <= cfg_data[4:0];
				wwpl_pkg::REG_WARMUP:      warmup_q      <= cfg_data[14:0];
				wwpl_pkg::REG_COOLDOWN:    cooldown_q    <= cfg_data[14:0];
				wwpl_pkg::REG_LISTEN_TIME: listen_time_q <= cfg_data[31:0];
				wwpl_pkg::REG_GAP_TIME:    gap_time_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q[wwpl_pkg::SLOT_WAKE] <= cleared(wwpl_pkg::DEF_WARMUP);
			slot_q[wwpl_pkg::SLOT_ON]   <= cleared('0);
			slot_q[wwpl_pkg::SLOT_OFF]  <= cleared('0);
			listen_q    <= 1'b0;
			deadline_q  <= '0;
			btime_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				slot_q     <= slot_d;
				listen_q   <= listen_d;
				deadline_q <= deadline_d;
				btime_q    <= btime_d;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q        <= ev_d;
			listening_q <= listen_d;
			hp_q        <= hp_d;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.event_res = ev_q;
	assign res.listening = listening_q;
	assign res.hit_prob  = hp_q;

	`WWPL_ASSERT(a_wake_listens, clk, arst_n, !(res_valid_q && ev_q == wwpl_pkg::EV_WAKE) || listening_q, "wake word without listen")
	`WWPL_ASSERT(a_end_idle, clk, arst_n, !(res_valid_q && (ev_q == wwpl_pkg::EV_ON || ev_q == wwpl_pkg::EV_OFF || ev_q == wwpl_pkg::EV_TIMEOUT)) || !listening_q, "listen kept after end")
	`WWPL_ASSERT(a_hp_zero, clk, arst_n, !(res_valid_q && (ev_q == wwpl_pkg::EV_NONE || ev_q == wwpl_pkg::EV_TIMEOUT || ev_q == wwpl_pkg::EV_GAP)) || hp_q == '0, "hit prob without hit")
	`WWPL_ASSERT(a_hold_nonpos, clk, arst_n, (slot_q[0].hold[15] || slot_q[0].hold == '0) && (slot_q[1].hold[15] || slot_q[1].hold == '0) && (slot_q[2].hold[15] || slot_q[2].hold == '0), "holdoff counter positive")
endmodule

[rtl/wake_word_posterior_listen_fsm.sv]
// Top level of the wake word and light command detector.
// Path: an accepted word is held in the queue, then its result is registered in the back end.
// Throughput: one word per cycle while the result output is not stalled; the back end updates its slots on each pop.
// The two-entry queue lets input and output stall independently.
// Reset (arst_n low): listen mode, times, windows and sums cleared at once,
// wake holdoff loaded with minus the warmup, config registers to defaults.
`timescale 1ns / 1ps
module wake_word_posterior_listen_fsm (
	input  logic                               clk,
	input  logic                               arst_n,
	wwpl_item_if.sink                          item,
	wwpl_res_if.source                         res,
	input  logic                               cfg_we,
	input  logic [wwpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wwpl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	wwpl_pkg::q_wr_t wr;
	wwpl_pkg::q_rd_t rd;
	logic            full;
	logic            pop;

	wwpl_front u_front (
		.item (item),
		.full (full),
		.wr   (wr)
	);

	wwpl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.rd     (rd),
		.pop    (pop)
	);

	wwpl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);
endmodule

[test/testbench.sv]
// Self-checking testbench for the wake word and light command detector.
`timescale 1ns / 1ps
module testbench;
	import wwpl_pkg::*;

	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef struct packed {
		event_t     ev;
		logic       listening;
		logic [7:0] hit;
	} detect_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wwpl_item_if item_ch();
	wwpl_res_if res_ch();

	wake_word_posterior_listen_fsm i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// detector configuration as last written
	logic [7:0] wake_cut_r, cmd_cut_r;
	logic [4:0] wake_len_r, cmd_len_r;
	logic [14:0] warm_r, cool_r;
	logic [31:0] listen_len_r, gap_r;

	// detector state
	logic listen_on;
	logic [TIME_WIDTH-1:0] deadline_us, prev_block_us, block_us;
	logic [7:0] win [NUM_SLOTS][WINDOW_MAX];
	int win_sum [NUM_SLOTS];
	int win_pos [NUM_SLOTS];
	int holdoff [NUM_SLOTS];
	logic [7:0] last_p [NUM_SLOTS];

	detect_t pending_detections[$];
	detect_t want;
	int bad_fields = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int unsigned cycle_count = 0;

	// stimulus state
	logic [TIME_WIDTH-1:0] clock_us;
	int burst_left = 0;
	logic [2:0] burst_mask = 3'b000;

	function automatic void clear_slot(int s, int load);
		for (int k = 0; k < WINDOW_MAX; k++)
			win[s][k] = 8'd0;
		win_sum[s] = 0;
		win_pos[s] = 0;
		holdoff[s] = load;
		last_p[s] = 8'd0;
	endfunction

	function automatic int slot_len(int s);
		int n;
		n = (s == SLOT_WAKE) ? int'(wake_len_r) : int'(cmd_len_r);
		if (n == 0)
			n = 1;
		if (n > WINDOW_MAX)
			n = WINDOW_MAX;
		return n;
	endfunction

	function automatic bit advance_slot(int s, logic d, logic [7:0] p);
		int n;
		int i;
		int cut;
		bit hit;
		hit = 1'b0;
		cut = (s == SLOT_WAKE) ? int'(wake_cut_r) : int'(cmd_cut_r);
		if (d) begin
			n = slot_len(s);
			i = win_pos[s] + 1;
			if (i >= n)
				i = 0;
			win_pos[s] = i;
			win_sum[s] = win_sum[s] - int'(win[s][i]) + int'(p);
			win[s][i] = p;
			last_p[s] = p;
			if (holdoff[s] >= 0 && win_sum[s] >= cut * n) begin
				hit = 1'b1;
				for (int k = 0; k < WINDOW_MAX; k++)
					win[s][k] = 8'd0;
				win_sum[s] = 0;
				holdoff[s] = -int'(cool_r);
			end
		end
		if (int'(last_p[s]) < cut && holdoff[s] < 0)
			holdoff[s]++;
		return hit;
	endfunction

	function automatic void leave_listen();
		listen_on = 1'b0;
		deadline_us = '0;
		clear_slot(SLOT_WAKE, -int'(cool_r));
	endfunction

	function automatic detect_t predict_detection(work_t w);
		detect_t r;
		logic [TIME_WIDTH-1:0] room;
		r.ev = EV_NONE;
		r.hit = 8'd0;
		if (w.op == OP_BLOCK) begin
			if (listen_on) begin
				if (w.now >= deadline_us) begin
					leave_listen();
					r.ev = EV_TIMEOUT;
				end
			end else if (prev_block_us != 0 && w.now > prev_block_us &&
					(w.now - prev_block_us) > TIME_WIDTH'(gap_r)) begin
				clear_slot(SLOT_WAKE, -int'(warm_r));
				r.ev = EV_GAP;
			end
			prev_block_us = w.now;
			block_us = w.now;
		end else if (listen_on) begin
			if (advance_slot(SLOT_ON, w.done[SLOT_ON], w.prob[SLOT_ON])) begin
				r.ev = EV_ON;
				r.hit = last_p[SLOT_ON];
				leave_listen();
			end else if (advance_slot(SLOT_OFF, w.done[SLOT_OFF], w.prob[SLOT_OFF])) begin
				r.ev = EV_OFF;
				r.hit = last_p[SLOT_OFF];
				leave_listen();
			end
		end else if (advance_slot(SLOT_WAKE, w.done[SLOT_WAKE], w.prob[SLOT_WAKE])) begin
			room = TIME_MAX - block_us;
			r.ev = EV_WAKE;
			r.hit = last_p[SLOT_WAKE];
			listen_on = 1'b1;
			deadline_us = (TIME_WIDTH'(listen_len_r) > room) ? TIME_MAX :
				block_us + TIME_WIDTH'(listen_len_r);
			clear_slot(SLOT_ON, -int'(warm_r));
			clear_slot(SLOT_OFF, -int'(warm_r));
		end
		r.listening = listen_on;
		return r;
	endfunction

	function automatic work_t block_word(logic [TIME_WIDTH-1:0] t);
		work_t w;
		w.op = OP_BLOCK;
		w.now = t;
		w.done = 3'($urandom);
		w.prob = 24'($urandom);
		return w;
	endfunction

	function automatic work_t slice_word(logic [2:0] mask, logic [7:0] wp, logic [7:0] onp,
			logic [7:0] offp);
		work_t w;
		w.op = OP_SLICE;
		w.now = TIME_WIDTH'({$urandom, $urandom});
		w.done = mask;
		w.prob[SLOT_WAKE] = wp;
		w.prob[SLOT_ON] = onp;
		w.prob[SLOT_OFF] = offp;
		return w;
	endfunction

	function automatic logic [TIME_WIDTH-1:0] next_block_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			clock_us = clock_us + TIME_WIDTH'($urandom_range(100, 3000));
		else if (r < 80)
			clock_us = clock_us + TIME_WIDTH'(gap_r) + TIME_WIDTH'($urandom_range(0, 2000));
		else if (r < 88)
			clock_us = clock_us - TIME_WIDTH'($urandom_range(1, 500));
		else if (r < 92)
			clock_us = clock_us;
		else if (r < 96)
			clock_us = block_us + TIME_WIDTH'(listen_len_r);
		else if (r < 99)
			clock_us = TIME_WIDTH'({$urandom, $urandom});
		else
			clock_us = '0;
		return clock_us;
	endfunction

	// mostly slices with bursts of high probabilities, some block starts, some noise
	function automatic work_t make_random_word();
		work_t w;
		int r;
		w = slice_word(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		r = $urandom_range(0, 99);
		if (r < 8) begin
			w.op = op_t'($urandom_range(0, 1));
			return w;
		end
		if (r < 26)
			return block_word(next_block_time());
		if (burst_left == 0 && $urandom_range(0, 11) == 0) begin
			burst_left = $urandom_range(2, 12);
			burst_mask = 3'($urandom_range(1, 7));
		end
		for (int s = 0; s < NUM_SLOTS; s++) begin
			w.done[s] = ($urandom_range(0, 99) < 85);
			if (burst_left > 0 && burst_mask[s])
				w.prob[s] = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(150, 255));
			else
				w.prob[s] = 8'($urandom_range(0, 120));
		end
		if (burst_left > 0)
			burst_left--;
		return w;
	endfunction

	task automatic send_word(work_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= w.op;
		item_ch.now_us <= w.now;
		item_ch.wake_done <= w.done[SLOT_WAKE];
		item_ch.wake_prob <= w.prob[SLOT_WAKE];
		item_ch.on_done <= w.done[SLOT_ON];
		item_ch.on_prob <= w.prob[SLOT_ON];
		item_ch.off_done <= w.done[SLOT_OFF];
		item_ch.off_prob <= w.prob[SLOT_OFF];
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_detections.push_back(predict_detection(w));
	endtask

	task automatic finish_stream();
		item_ch.valid <= 1'b0;
		while (pending_detections.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_WAKE_CUTOFF: wake_cut_r = v[7:0];
			REG_CMD_CUTOFF:  cmd_cut_r = v[7:0];
			REG_WAKE_LEN:    wake_len_r = v[4:0];
			REG_CMD_LEN:     cmd_len_r = v[4:0];
			REG_WARMUP:      warm_r = v[14:0];
			REG_COOLDOWN:    cool_r = v[14:0];
			REG_LISTEN_TIME: listen_len_r = v;
			REG_GAP_TIME:    gap_r = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// upper data bits are random: only the register width must be kept
	task automatic configure(logic [7:0] cw, logic [7:0] cc, logic [4:0] lw, logic [4:0] lc,
			logic [14:0] wu, logic [14:0] cd, logic [31:0] lt, logic [31:0] gt);
		write_reg(REG_WAKE_CUTOFF, {24'($urandom), cw});
		write_reg(REG_CMD_CUTOFF, {24'($urandom), cc});
		write_reg(REG_WAKE_LEN, {27'($urandom), lw});
		write_reg(REG_CMD_LEN, {27'($urandom), lc});
		write_reg(REG_WARMUP, {17'($urandom), wu});
		write_reg(REG_COOLDOWN, {17'($urandom), cd});
		write_reg(REG_LISTEN_TIME, lt);
		write_reg(REG_GAP_TIME, gt);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int n);
		for (int k = 0; k < n; k++)
			send_word(make_random_word());
		finish_stream();
	endtask

	task automatic test_defaults();
		send_word(block_word('0));
		send_word(slice_word(3'b111, 8'd255, 8'd255, 8'd255));
		send_word(block_word(TIME_MAX));
		send_word(block_word(TIME_WIDTH'(1)));
		finish_stream();
	endtask

	task automatic test_directed_events();
		configure(8'd100, 8'd100, 5'd2, 5'd1, 15'd1, 15'd2, 32'd10, 32'd5);
		send_word(block_word(TIME_WIDTH'(100)));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd255, 8'd0, 8'd0));
		send_word(slice_word(3'b000, 8'd255, 8'd255, 8'd255));
		send_word(slice_word(3'b010, 8'd0, 8'd255, 8'd0));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd255, 8'd0, 8'd0));
		send_word(slice_word(3'b000, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b100, 8'd0, 8'd0, 8'd255));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd255, 8'd0, 8'd0));
		send_word(block_word(TIME_WIDTH'(109)));
		send_word(block_word(TIME_WIDTH'(110)));
		send_word(block_word(TIME_WIDTH'(116)));
		send_word(block_word(TIME_WIDTH'(121)));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd255, 8'd0, 8'd0));
		send_word(block_word(TIME_MAX - 3));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd0, 8'd0, 8'd0));
		send_word(slice_word(3'b001, 8'd255, 8'd0, 8'd0));
		send_word(block_word(TIME_MAX));
		finish_stream();
	endtask

	task automatic test_no_idle();
		send_idle_pct = 0;
		stall_pct = 0;
		clock_us = TIME_WIDTH'(1000);
		configure(8'd150, 8'd150, 5'd4, 5'd3, 15'd3, 15'd5, 32'd6000, 32'd9000);
		run_random(380);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 63;
		stall_pct = 0;
		configure(8'd170, 8'd140, 5'd6, 5'd2, 15'd8, 15'd2, 32'd4000, 32'd3000);
		run_random(380);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		stall_pct = 63;
		configure(8'd130, 8'd160, 5'd3, 5'd5, 15'd0, 15'd10, 32'd12000, 32'd2500);
		run_random(380);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 24;
		stall_pct = 24;
		configure(8'd150, 8'd150, 5'd8, 5'd4, 15'd5, 15'd6, 32'd8000, 32'd7000);
		run_random(380);
	endtask

	task automatic test_high_extremes();
		send_idle_pct = 0;
		stall_pct = 0;
		configure(8'd255, 8'd255, 5'd16, 5'd16, 15'd0, 15'd0, 32'hFFFF_FFFF, 32'd1);
		run_random(150);
	endtask

	// length zero acts as one, length above the maximum saturates
	task automatic test_low_extremes();
		send_idle_pct = 24;
		stall_pct = 24;
		configure(8'd0, 8'd0, 5'd0, 5'd31, 15'd32767, 15'd32767, 32'd1, 32'hFFFF_FFFF);
		run_random(100);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		configure(8'd140, 8'd140, 5'd2, 5'd2, 15'd1, 15'd1, 32'd5000, 32'd6000);
		for (int k = 0; k < 4; k++)
			send_word(make_random_word());
		hold_left = 400;
		for (int k = 0; k < 60; k++)
			send_word(make_random_word());
		finish_stream();
		run_random(100);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_detections.size() == 0) begin
					$error("result word with nothing expected: event_res %0d",
						res_ch.event_res);
					bad_fields++;
				end else begin
					want = pending_detections.pop_front();
					if (res_ch.event_res !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, res_ch.event_res);
						bad_fields++;
					end
					if (res_ch.listening !== want.listening) begin
						$error("listening: expected %0d, got %0d", want.listening,
							res_ch.listening);
						bad_fields++;
					end
					if (res_ch.hit_prob !== want.hit) begin
						$error("hit_prob: expected %0d, got %0d", want.hit, res_ch.hit_prob);
						bad_fields++;
					end
				end
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wake_word_posterior_listen_fsm regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = OP_BLOCK;
		item_ch.now_us = '0;
		item_ch.wake_done = 1'b0;
		item_ch.wake_prob = 8'd0;
		item_ch.on_done = 1'b0;
		item_ch.on_prob = 8'd0;
		item_ch.off_done = 1'b0;
		item_ch.off_prob = 8'd0;
		res_ch.ready = 1'b0;
		wake_cut_r = DEF_WAKE_CUTOFF;
		cmd_cut_r = DEF_CMD_CUTOFF;
		wake_len_r = DEF_WAKE_LEN;
		cmd_len_r = DEF_CMD_LEN;
		warm_r = DEF_WARMUP;
		cool_r = DEF_COOLDOWN;
		listen_len_r = DEF_LISTEN_TIME;
		gap_r = DEF_GAP_TIME;
		listen_on = 1'b0;
		deadline_us = '0;
		prev_block_us = '0;
		block_us = '0;
		clock_us = '0;
		clear_slot(SLOT_WAKE, -int'(DEF_WARMUP));
		clear_slot(SLOT_ON, 0);
		clear_slot(SLOT_OFF, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_directed_events();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_high_extremes();
		test_low_extremes();
		test_backpressure();
		repeat (4) @(posedge clk);
		if (bad_fields == 0 && pending_detections.size() == 0)
			$display("wake_word_posterior_listen_fsm regression: pass");
		else
			$display("wake_word_posterior_listen_fsm regression: fail");
		$finish;
	end
endmodule
